// ===== rtl/core/aur_pkg.sv =====
// Package for the alpha unpremultiply block: pixel layout, per-stage data types,
// and the lane preparation that feeds the divider chain.
// No dependencies.
package aur_pkg;

    // Pixel and channel geometry
    localparam int CHAN_W    = 8;
    localparam int PIXEL_W   = 32;
    localparam int NUM_LANES = 3;

    // One restoring-division cell per quotient bit
    localparam int NUM_CELLS = CHAN_W;

    // Lane indexes for the colour channels
    localparam int LANE_R = 2;
    localparam int LANE_G = 1;
    localparam int LANE_B = 0;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // One colour channel in flight: partial remainder, shifting dividend/quotient word
    typedef struct packed {
        logic              bypass;
        logic [CHAN_W-1:0] rem;
        logic [CHAN_W-1:0] low;
    } lane_t;

    // Everything one stage hands to the next
    typedef struct packed {
        logic [CHAN_W-1:0]           alpha;
        lane_t [NUM_LANES-1:0]       lane;
    } stage_t;

    // Set up one channel for division by alpha.
    // Zero alpha passes the channel through; a channel at or above alpha saturates.
    function automatic lane_t prep_lane(input logic [CHAN_W-1:0] chan,
                                        input logic [CHAN_W-1:0] alpha);
        logic [2*CHAN_W-1:0] prod;
        lane_t               l;
        prod = {chan, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, chan};
        if (alpha == '0) begin
            l.bypass = 1'b1;
            l.rem    = '0;
            l.low    = chan;
        end else if (chan >= alpha) begin
            l.bypass = 1'b1;
            l.rem    = '0;
            l.low    = CHAN_MAX;
        end else begin
            l.bypass = 1'b0;
            l.rem    = prod[2*CHAN_W-1:CHAN_W];
            l.low    = prod[CHAN_W-1:0];
        end
        return l;
    endfunction

endpackage

// ===== rtl/core/argb_unpremultiply_to_rgba_top.sv =====
// Alpha unpremultiply, ARGB32 premultiplied in, RGBA-ordered straight alpha out.
// A request passes the registered cells of the chain to done, one cell per quotient bit.
// Throughput: one request per cycle; busy stays low, the chain advances every cycle.
// Reset clears the valid flags of all cells; data in flight is dropped.
// The receiver cannot stall: done is a one-cycle strobe. Depends on aur_pkg, aur_cell.
module argb_unpremultiply_to_rgba_top
    import aur_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [PIXEL_W-1:0] pixel_in,
    output logic               done,
    output logic [PIXEL_W-1:0] pixel_out
);

    logic   accept;
    stage_t entry;
    logic   chain_valid [NUM_CELLS+1];
    stage_t chain_data  [NUM_CELLS+1];

    // The chain never blocks a request
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Unpack the pixel and set up each lane for division
    always_comb
    begin
        entry.alpha            = pixel_in[31:24];
        entry.lane[LANE_R]     = prep_lane(pixel_in[23:16], pixel_in[31:24]);
        entry.lane[LANE_G]     = prep_lane(pixel_in[15:8],  pixel_in[31:24]);
        entry.lane[LANE_B]     = prep_lane(pixel_in[7:0],   pixel_in[31:24]);
    end

    assign chain_valid[0] = accept;
    assign chain_data[0]  = entry;

    // Build the divider chain
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        aur_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    // Repack with red and blue swapped
    assign done      = chain_valid[NUM_CELLS];
    assign pixel_out = {chain_data[NUM_CELLS].alpha,
                        chain_data[NUM_CELLS].lane[LANE_B].low,
                        chain_data[NUM_CELLS].lane[LANE_G].low,
                        chain_data[NUM_CELLS].lane[LANE_R].low};

    // Every accepted request comes out as a done strobe at the end of the chain
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##NUM_CELLS done)
        else $error("accepted request did not complete on time");

    // No result without a matching request
    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, NUM_CELLS))
        else $error("result without a request");

    // Alpha travels unchanged
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> pixel_out[31:24] == $past(pixel_in[31:24], NUM_CELLS))
        else $error("alpha corrupted");

    // Zero alpha passes colour through with red and blue swapped
    a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        done && pixel_out[31:24] == 8'h00 |->
            pixel_out[23:0] == {$past(pixel_in[7:0], NUM_CELLS),
                                $past(pixel_in[15:8], NUM_CELLS),
                                $past(pixel_in[23:16], NUM_CELLS)})
        else $error("zero-alpha pass-through broken");

endmodule

// ===== rtl/core/aur_cell.sv =====
// One cell of the divider chain: retires one quotient bit for each colour lane
// that is not bypassed and registers the result for the next cell. Depends on aur_pkg.
module aur_cell
    import aur_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  stage_t in_data,
    output logic   out_valid,
    output stage_t out_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    // Shift in the next dividend bit, subtract alpha when it fits; bypassed lanes hold
    always_comb
    begin
        logic [CHAN_W:0] trial;
        logic            fits;
        data_next.alpha = in_data.alpha;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            trial = {in_data.lane[i].rem, in_data.lane[i].low[CHAN_W-1]};
            fits  = (trial >= {1'b0, in_data.alpha});
            data_next.lane[i].bypass = in_data.lane[i].bypass;
            if (in_data.lane[i].bypass)
            begin
                data_next.lane[i].rem = in_data.lane[i].rem;
                data_next.lane[i].low = in_data.lane[i].low;
            end
            else
            begin
                data_next.lane[i].rem = fits ? CHAN_W'(trial - {1'b0, in_data.alpha})
                                             : trial[CHAN_W-1:0];
                data_next.lane[i].low = {in_data.lane[i].low[CHAN_W-2:0], fits};
            end
        end
    end

    // Advance the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
